>>> src/rpwc_pkg.sv
// ----------------------------------------------------------------------------
// rpwc_pkg
// Types and constants for the remote pulse width capture core.
// ----------------------------------------------------------------------------
package rpwc_pkg;

    typedef enum logic [1:0] {
        KIND_PULSE   = 2'd0,
        KIND_SUCCESS = 2'd1,
        KIND_FAIL    = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        REG_GLITCH_SAMPLES  = 2'd0,
        REG_IDLE_GAP        = 2'd1,
        REG_MIN_PULSE_UNITS = 2'd2,
        REG_MIN_PULSES      = 2'd3
    } reg_index_t;

    localparam int CFG_DATA_W = 12;
    localparam int RUN_W      = 12;
    localparam int MIS_W      = 4;
    localparam int DUR_W      = 8;
    localparam int IDX_W      = 9;

    localparam logic [MIS_W-1:0]  GLITCH_RESET    = 4'd5;
    localparam logic [RUN_W-1:0]  IDLE_GAP_RESET  = 12'd1000;
    localparam logic [DUR_W-1:0]  MIN_UNITS_RESET = 8'd4;
    localparam logic [IDX_W-1:0]  MIN_PULSES_RESET = 9'd20;

    localparam logic [RUN_W-1:0]  RUN_MAX  = 12'd4095;
    localparam logic [MIS_W-1:0]  MIS_MAX  = 4'd15;
    localparam logic [RUN_W:0]    LEN_SAT  = 13'd1020;
    localparam logic [DUR_W-1:0]  DUR_MAX  = 8'd255;

    localparam int FIFO_DEPTH = 4;

    typedef struct packed {
        kind_t              kind;
        logic [DUR_W-1:0]   duration;
        logic [IDX_W-1:0]   index;
        logic               last;
    } result_t;

endpackage

>>> src/remote_pulse_width_capture_core.sv
// ----------------------------------------------------------------------------
// remote_pulse_width_capture_core
// Debounced pulse width capture of a sampled receiver line, framed by long
// low gaps, with a small result queue on the output stream.
// ----------------------------------------------------------------------------
// channel   dir  handshake            payload
// s_*       in   s_tvalid/s_tready    tdata: sample, abort
// m_*       out  m_tvalid/m_tready    tdata: duration, index; tuser: kind;
//                                     tlast: last
// cfg_*     in   cfg_wen              cfg_index, cfg_data
//
// One input transaction per cycle while s_tready is high; each produces zero,
// one or two results, which are registered in the queue and offered from its head.
// Results enter a four-entry queue; s_tready is low while fewer than two
// entries are free, so a stalled output stops the input once three results wait.
// Reset restores register defaults, clears the capture state and empties the queue.
// ----------------------------------------------------------------------------
module remote_pulse_width_capture_core
    import rpwc_pkg::*;
#(
    parameter int MAX_PULSES = 256
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [7:0]              s_tdata,   // [0] sample, [1] abort
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [23:0]             m_tdata,   // [7:0] duration, [16:8] index
    output logic [1:0]              m_tuser,   // [1:0] kind
    output logic                    m_tlast,
    input  logic                    cfg_wen,
    input  logic [1:0]              cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data
);

    localparam int PW  = $clog2(MAX_PULSES + 1);
    localparam int EW  = (PW > IDX_W) ? PW : IDX_W;
    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    logic [MIS_W-1:0]   glitch_reg;
    logic [RUN_W-1:0]   idle_gap_reg;
    logic [DUR_W-1:0]   min_units_reg;
    logic [IDX_W-1:0]   min_pulses_reg;

    logic               level_reg, level_next;
    logic [RUN_W-1:0]   run_reg, run_next;
    logic [MIS_W-1:0]   mis_reg, mis_next;
    logic               in_frame_reg, in_frame_next;
    logic [PW-1:0]      pidx_reg, pidx_next;

    result_t            fifo_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    logic               in_acc, out_acc;
    logic               smp, abort_req;
    logic [1:0]         n_res;
    result_t            res0, res1;
    logic [RUN_W:0]     sum, len;
    logic [MIS_W-1:0]   mis_inc, need;
    logic [DUR_W-1:0]   dur;
    logic               gap, finish, rearm;
    logic [PW-1:0]      pidx_new;
    logic [EW-1:0]      pidx_ext, pidx_new_ext;
    result_t            head;

    assign in_acc    = s_tvalid && s_tready;
    assign out_acc   = m_tvalid && m_tready;
    assign smp       = s_tdata[0];
    assign abort_req = s_tdata[1];
    assign pidx_ext  = EW'(pidx_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            glitch_reg     <= GLITCH_RESET;
            idle_gap_reg   <= IDLE_GAP_RESET;
            min_units_reg  <= MIN_UNITS_RESET;
            min_pulses_reg <= MIN_PULSES_RESET;
        end
        else if (cfg_wen)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_GLITCH_SAMPLES:  glitch_reg     <= cfg_data[MIS_W-1:0];
                REG_IDLE_GAP:        idle_gap_reg   <= cfg_data[RUN_W-1:0];
                REG_MIN_PULSE_UNITS: min_units_reg  <= cfg_data[DUR_W-1:0];
                REG_MIN_PULSES:      min_pulses_reg <= cfg_data[IDX_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        level_next    = level_reg;
        run_next      = run_reg;
        mis_next      = mis_reg;
        in_frame_next = in_frame_reg;
        pidx_next     = pidx_reg;
        n_res         = 2'd0;
        res0          = '0;
        res1          = '0;
        sum           = '0;
        len           = '0;
        mis_inc       = '0;
        need          = '0;
        dur           = '0;
        gap           = 1'b0;
        finish        = 1'b0;
        rearm         = 1'b0;
        pidx_new      = pidx_reg;
        pidx_new_ext  = '0;

        if (in_acc)
        begin
            if (abort_req)
            begin
                res0  = '{KIND_FAIL, '0, pidx_ext[IDX_W-1:0], 1'b1};
                n_res = 2'd1;
                rearm = 1'b1;
            end
            else if (smp == level_reg)
            begin
                sum      = {1'b0, run_reg} + (RUN_W+1)'(mis_reg) + 1'b1;
                run_next = (sum > {1'b0, RUN_MAX}) ? RUN_MAX : sum[RUN_W-1:0];
                mis_next = '0;
            end
            else
            begin
                mis_inc = (mis_reg == MIS_MAX) ? MIS_MAX : mis_reg + 1'b1;
                need    = (glitch_reg == '0) ? MIS_W'(1) : glitch_reg;
                if (mis_inc < need)
                begin
                    mis_next = mis_inc;
                end
                else
                begin
                    len = {1'b0, run_reg} + (RUN_W+1)'(mis_inc);
                    dur = (len > LEN_SAT) ? DUR_MAX : len[DUR_W+1:2];
                    if ((len <= LEN_SAT) && (dur < min_units_reg))
                    begin
                        res0  = '{KIND_FAIL, '0, pidx_ext[IDX_W-1:0], 1'b1};
                        n_res = 2'd1;
                        rearm = 1'b1;
                    end
                    else
                    begin
                        gap = !level_reg && (run_reg > idle_gap_reg);
                        if (in_frame_reg)
                        begin
                            res0     = '{KIND_PULSE, dur, pidx_ext[IDX_W-1:0], 1'b0};
                            n_res    = 2'd1;
                            pidx_new = pidx_reg + 1'b1;
                            finish   = gap || (pidx_new >= PW'(MAX_PULSES));
                        end
                        else if (gap)
                        begin
                            res0     = '{KIND_PULSE, dur, '0, 1'b0};
                            n_res    = 2'd1;
                            pidx_new = PW'(1);
                            finish   = (pidx_new >= PW'(MAX_PULSES));
                        end
                        pidx_new_ext = EW'(pidx_new);
                        if (finish)
                        begin
                            res1.kind     = (pidx_new_ext >= EW'(min_pulses_reg)) ?
                                            KIND_SUCCESS : KIND_FAIL;
                            res1.duration = '0;
                            res1.index    = pidx_new_ext[IDX_W-1:0];
                            res1.last     = 1'b1;
                            n_res         = 2'd2;
                            rearm         = 1'b1;
                        end
                        else
                        begin
                            level_next    = !level_reg;
                            run_next      = '0;
                            mis_next      = '0;
                            in_frame_next = in_frame_reg || gap;
                            pidx_next     = pidx_new;
                        end
                    end
                end
            end

            if (rearm)
            begin
                level_next    = 1'b0;
                run_next      = '0;
                mis_next      = '0;
                in_frame_next = 1'b0;
                pidx_next     = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg    <= 1'b0;
            run_reg      <= '0;
            mis_reg      <= '0;
            in_frame_reg <= 1'b0;
            pidx_reg     <= '0;
        end
        else
        begin
            level_reg    <= level_next;
            run_reg      <= run_next;
            mis_reg      <= mis_next;
            in_frame_reg <= in_frame_next;
            pidx_reg     <= pidx_next;
        end
    end

    // result queue
    always_ff @(posedge clk)
    begin
        if (n_res != 2'd0)
        begin
            fifo_reg[wr_ptr_reg] <= res0;
        end
        if (n_res == 2'd2)
        begin
            fifo_reg[wr_ptr_reg + 1'b1] <= res1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(n_res);
            if (out_acc)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + CNT_W'(n_res) - CNT_W'(out_acc);
        end
    end

    assign head     = fifo_reg[rd_ptr_reg];
    assign s_tready = (count_reg <= CNT_W'(FIFO_DEPTH - 2));
    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = {7'd0, head.index, head.duration};
    assign m_tuser  = head.kind;
    assign m_tlast  = head.last;

endmodule

>>> src/rpwc_checker.sv
// ----------------------------------------------------------------------------
// rpwc_checker
// Port-level checks for the remote pulse width capture core.
// ----------------------------------------------------------------------------
module rpwc_checker
    import rpwc_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [7:0]   s_tdata,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [23:0]  m_tdata,
    input logic [1:0]   m_tuser,
    input logic         m_tlast
);

    // stalled output transaction stays offered
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped under stall");

    // tlast marks exactly the completion results
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (m_tuser != KIND_PULSE)))
        else $error("tlast disagrees with kind");

    // completion results carry zero duration, padding stays zero
    a_dur: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((!m_tlast || m_tdata[7:0] == 8'd0) && m_tdata[23:17] == 7'd0))
        else $error("bad duration or padding");

    // an abort always queues a result
    a_abort: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tdata[1] |=> m_tvalid)
        else $error("abort gave no result");

endmodule

bind remote_pulse_width_capture_core rpwc_checker u_rpwc_checker (.*);
